// ----- hdl/sync_word_frame_deframer_top_defines.svh -----
// Assertion macros used by the deframer top-level RTL.
`ifndef SYNC_WORD_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define SYNC_WORD_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SWFD_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("SWFD same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SWFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("SWFD next-cycle check failed");

`endif

// ----- hdl/swfd_pkg.sv -----
package swfd_pkg;

  localparam int unsigned HEADER_BYTES_DEF = 20;
  localparam int unsigned HDR_OFF_W        = 6;
  localparam int unsigned HDR_STORE_BYTES  = 16;
  localparam int unsigned HDR_STORE_FIRST  = 4;
  localparam int unsigned HDR_STORE_END    = 20;
  localparam int unsigned OUT_DATA_W       = 128;

  localparam logic [1:0] KIND_HDR_OK  = 2'd0;
  localparam logic [1:0] KIND_POINT   = 2'd1;
  localparam logic [1:0] KIND_TIME    = 2'd2;
  localparam logic [1:0] KIND_HDR_BAD = 2'd3;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_VERSION  = 2'd1;
  localparam logic [1:0] ERR_POINTS   = 2'd2;
  localparam logic [1:0] ERR_TIMES    = 2'd3;

  localparam logic [1:0] REG_SYNC_WORD   = 2'd0;
  localparam logic [1:0] REG_EXP_VERSION = 2'd1;
  localparam logic [1:0] REG_MAX_POINTS  = 2'd2;
  localparam logic [1:0] REG_MAX_TIMES   = 2'd3;

  typedef struct packed {
    logic [31:0] sync_word;
    logic [7:0]  expected_version;
    logic [7:0]  max_points;
    logic [7:0]  max_time_samples;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  error_code;
    logic [15:0] sequence_res;
    logic [7:0]  frame_flags;
    logic [7:0]  point_total;
    logic [7:0]  time_total;
    logic [31:0] peak_bits;
    logic [31:0] rms_bits;
    logic [7:0]  sample_value;
    logic [7:0]  sample_index;
    logic        frame_last;
  } result_t;

endpackage

// ----- hdl/swfd_parser.sv -----
module swfd_parser #(
  parameter int unsigned HEADER_BYTES = swfd_pkg::HEADER_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  input  swfd_pkg::cfg_t   cfg_i,
  output logic             res_valid_o,
  output swfd_pkg::result_t res_o
);

  localparam int unsigned OffW = swfd_pkg::HDR_OFF_W;
  localparam logic [OffW:0] HdrLen = (OffW + 1)'(HEADER_BYTES);
  localparam logic [OffW-1:0] StoreFirst = OffW'(swfd_pkg::HDR_STORE_FIRST);
  localparam logic [OffW-1:0] StoreEnd = OffW'(swfd_pkg::HDR_STORE_END);

  localparam logic [1:0] PH_HUNT   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_POINTS = 2'd2;
  localparam logic [1:0] PH_TIMES  = 2'd3;

  logic [1:0]      phase_q, phase_d;
  logic [31:0]     win_q, win_d;
  logic [2:0]      fill_q, fill_d;
  logic [OffW-1:0] hoff_q, hoff_d;
  logic [7:0]      poff_q, poff_d;
  logic [7:0]      hdr_q [swfd_pkg::HDR_STORE_BYTES];
  logic [7:0]      hdr_d [swfd_pkg::HDR_STORE_BYTES];

  logic [31:0]     win_shift;
  logic [2:0]      fill_inc;
  logic [OffW-1:0] store_off;
  logic [3:0]      store_idx;
  logic [15:0]     pts16, tms16;
  logic [1:0]      err;
  logic [7:0]      total;
  logic            section_end, last;

  assign win_shift = {byte_i, win_q[31:8]};
  assign fill_inc  = (fill_q < 3'd4) ? fill_q + 3'd1 : fill_q;
  assign store_off = hoff_q - StoreFirst;
  assign store_idx = store_off[3:0];

  always_comb begin
    for (int i = 0; i < int'(swfd_pkg::HDR_STORE_BYTES); i++) begin
      hdr_d[i] = hdr_q[i];
    end
    if (phase_q == PH_HEADER && hoff_q >= StoreFirst && hoff_q < StoreEnd) begin
      hdr_d[store_idx] = byte_i;
    end
  end

  assign pts16 = {hdr_d[5], hdr_d[4]};
  assign tms16 = {hdr_d[7], hdr_d[6]};

  always_comb begin
    if (hdr_d[0] != cfg_i.expected_version) begin
      err = swfd_pkg::ERR_VERSION;
    end else if (pts16 == 16'd0 || pts16 > {8'd0, cfg_i.max_points}) begin
      err = swfd_pkg::ERR_POINTS;
    end else if (tms16 > {8'd0, cfg_i.max_time_samples}) begin
      err = swfd_pkg::ERR_TIMES;
    end else begin
      err = swfd_pkg::ERR_NONE;
    end
  end

  assign total       = (phase_q == PH_POINTS) ? hdr_d[4] : hdr_d[6];
  assign section_end = ({1'b0, poff_q} + 9'd1) >= {1'b0, total};
  assign last        = section_end && (phase_q == PH_TIMES || hdr_d[6] == 8'd0);

  always_comb begin
    phase_d = phase_q;
    win_d   = win_q;
    fill_d  = fill_q;
    hoff_d  = hoff_q;
    poff_d  = poff_q;
    res_valid_o = 1'b0;

    res_o.result_kind  = swfd_pkg::KIND_HDR_OK;
    res_o.error_code   = swfd_pkg::ERR_NONE;
    res_o.sequence_res = {hdr_d[3], hdr_d[2]};
    res_o.frame_flags  = hdr_d[1];
    res_o.point_total  = hdr_d[4];
    res_o.time_total   = hdr_d[6];
    res_o.peak_bits    = {hdr_d[11], hdr_d[10], hdr_d[9], hdr_d[8]};
    res_o.rms_bits     = {hdr_d[15], hdr_d[14], hdr_d[13], hdr_d[12]};
    res_o.sample_value = 8'd0;
    res_o.sample_index = 8'd0;
    res_o.frame_last   = 1'b0;

    unique case (phase_q)
      PH_HUNT: begin
        win_d  = win_shift;
        fill_d = fill_inc;
        if (fill_inc >= 3'd4 && win_shift == cfg_i.sync_word) begin
          phase_d = PH_HEADER;
          hoff_d  = StoreFirst;
        end
      end
      PH_HEADER: begin
        if (({1'b0, hoff_q} + (OffW + 1)'(1)) < HdrLen) begin
          hoff_d = hoff_q + OffW'(1);
        end else begin
          res_valid_o = 1'b1;
          if (err != swfd_pkg::ERR_NONE) begin
            res_o.result_kind = swfd_pkg::KIND_HDR_BAD;
            res_o.error_code  = err;
            res_o.frame_last  = 1'b1;
            phase_d = PH_HUNT;
            win_d   = '0;
            fill_d  = '0;
            hoff_d  = '0;
            poff_d  = '0;
          end else begin
            phase_d = PH_POINTS;
            hoff_d  = '0;
            poff_d  = '0;
          end
        end
      end
      PH_POINTS, PH_TIMES: begin
        res_valid_o = 1'b1;
        res_o.result_kind  = (phase_q == PH_POINTS) ? swfd_pkg::KIND_POINT
                                                    : swfd_pkg::KIND_TIME;
        res_o.sample_value = byte_i;
        res_o.sample_index = poff_q;
        res_o.frame_last   = last;
        if (last) begin
          phase_d = PH_HUNT;
          win_d   = '0;
          fill_d  = '0;
          hoff_d  = '0;
          poff_d  = '0;
        end else if (section_end) begin
          phase_d = PH_TIMES;
          poff_d  = '0;
        end else begin
          poff_d  = poff_q + 8'd1;
        end
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      win_q   <= '0;
      fill_q  <= '0;
      hoff_q  <= '0;
      poff_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      win_q   <= win_d;
      fill_q  <= fill_d;
      hoff_q  <= hoff_d;
      poff_q  <= poff_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      for (int i = 0; i < int'(swfd_pkg::HDR_STORE_BYTES); i++) begin
        hdr_q[i] <= hdr_d[i];
      end
    end
  end

endmodule

// ----- hdl/sync_word_frame_deframer_top.sv -----
// Byte-stream frame deframer. It takes one byte per clock for as long as results are taken;
// one output register holds the result of the previous byte and the input stalls only while
// that register is full and the sink holds tready low. Hunting compares a four-byte window
// against sync_word, the rest of a HEADER_BYTES-byte header (counting the sync word) follows,
// and after an accepted header every point byte and time byte is sent with the header fields
// repeated, tlast marking the final byte or a rejected header.
// Configuration writes take effect on the next cycle and should be made while idle.
`include "sync_word_frame_deframer_top_defines.svh"

module sync_word_frame_deframer_top #(
  parameter int unsigned HEADER_BYTES = swfd_pkg::HEADER_BYTES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // tdata: data_byte [7:0]
  input  logic [7:0]   s_axis_tdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: error_code [1:0], sequence_res [17:2], frame_flags [25:18], point_total [33:26],
  // time_total [41:34], peak_bits [73:42], rms_bits [105:74], sample_value [113:106],
  // sample_index [121:114], zero fill [127:122]
  output logic [swfd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: result_kind [1:0]
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_addr_i,
  input  logic [31:0]  cfg_wdata_i
);

  swfd_pkg::cfg_t    cfg_q;
  swfd_pkg::result_t res;
  swfd_pkg::result_t out_q;
  logic              res_valid;
  logic              out_valid_q, out_valid_d;
  logic              in_acc;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  swfd_parser #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (in_acc),
    .byte_i     (s_axis_tdata),
    .cfg_i      (cfg_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_word        <= '0;
      cfg_q.expected_version <= 8'd1;
      cfg_q.max_points       <= 8'd255;
      cfg_q.max_time_samples <= 8'd255;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        swfd_pkg::REG_SYNC_WORD:   cfg_q.sync_word        <= cfg_wdata_i;
        swfd_pkg::REG_EXP_VERSION: cfg_q.expected_version <= cfg_wdata_i[7:0];
        swfd_pkg::REG_MAX_POINTS:  cfg_q.max_points       <= cfg_wdata_i[7:0];
        swfd_pkg::REG_MAX_TIMES:   cfg_q.max_time_samples <= cfg_wdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = res_valid;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.result_kind;
  assign m_axis_tlast  = out_q.frame_last;
  assign m_axis_tdata  = {6'd0, out_q.sample_index, out_q.sample_value, out_q.rms_bits,
                          out_q.peak_bits, out_q.time_total, out_q.point_total,
                          out_q.frame_flags, out_q.sequence_res, out_q.error_code};

  `SWFD_ASSERT_SAME(a_hdr_ok_clean, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == swfd_pkg::KIND_HDR_OK, !m_axis_tlast && out_q.error_code == swfd_pkg::ERR_NONE)
  `SWFD_ASSERT_SAME(a_hdr_bad_marked, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == swfd_pkg::KIND_HDR_BAD, m_axis_tlast && out_q.error_code != swfd_pkg::ERR_NONE)
  `SWFD_ASSERT_SAME(a_point_in_range, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == swfd_pkg::KIND_POINT, out_q.sample_index < out_q.point_total)
  `SWFD_ASSERT_NEXT(a_res_captured, clk_i, rst_ni, in_acc && res_valid, m_axis_tvalid)

endmodule

// ----- tb/swfd_frame_checker.sv -----
module swfd_frame_checker #(
  parameter int unsigned HEADER_BYTES = swfd_pkg::HEADER_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [7:0]                      s_tdata_i,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  input  logic [swfd_pkg::OUT_DATA_W-1:0] m_tdata_i,
  input  logic [1:0]                      m_tuser_i,
  input  logic                            m_tlast_i,
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_addr_i,
  input  logic [31:0]                     cfg_wdata_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     due_count_o,
  output int unsigned                     hdr_ok_count_o,
  output int unsigned                     bad_version_count_o,
  output int unsigned                     bad_points_count_o,
  output int unsigned                     bad_times_count_o,
  output int unsigned                     payload_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import swfd_pkg::*;

  typedef enum logic [1:0] {HUNTING, IN_HEADER, IN_POINTS, IN_TIMES} deframe_phase_e;

  cfg_t           regs;
  deframe_phase_e phase;
  logic [31:0]    sync_window;
  logic [2:0]     window_fill;
  logic [5:0]     hdr_offset;
  logic [7:0]     hdr_bytes [16];
  logic [7:0]     payload_offset;
  result_t        due_frame_results [$];
  result_t        want;

  task automatic rearm_hunt();
    phase          = HUNTING;
    sync_window    = '0;
    window_fill    = '0;
    hdr_offset     = '0;
    payload_offset = '0;
  endtask

  function automatic result_t frame_header_result(input logic [1:0] kind,
                                                  input logic [1:0] err,
                                                  input logic       last);
    result_t r;
    r.result_kind  = kind;
    r.error_code   = err;
    r.sequence_res = {hdr_bytes[3], hdr_bytes[2]};
    r.frame_flags  = hdr_bytes[1];
    r.point_total  = hdr_bytes[4];
    r.time_total   = hdr_bytes[6];
    r.peak_bits    = {hdr_bytes[11], hdr_bytes[10], hdr_bytes[9], hdr_bytes[8]};
    r.rms_bits     = {hdr_bytes[15], hdr_bytes[14], hdr_bytes[13], hdr_bytes[12]};
    r.sample_value = '0;
    r.sample_index = '0;
    r.frame_last   = last;
    return r;
  endfunction

  task automatic advance_deframer(input logic [7:0] b);
    logic [15:0] pts;
    logic [15:0] tms;
    logic [1:0]  err;
    logic [7:0]  total;
    logic        in_points;
    logic        section_end;
    logic        frame_end;
    result_t     r;
    case (phase)
      HUNTING: begin
        sync_window = {b, sync_window[31:8]};
        if (window_fill < 3'd4) window_fill = window_fill + 3'd1;
        if (window_fill == 3'd4 && sync_window == regs.sync_word) begin
          phase      = IN_HEADER;
          hdr_offset = 6'd4;
        end
      end
      IN_HEADER: begin
        if (hdr_offset >= 6'd4 && hdr_offset < 6'd20) hdr_bytes[4'(hdr_offset - 6'd4)] = b;
        if (int'(hdr_offset) + 1 < HEADER_BYTES) begin
          hdr_offset = hdr_offset + 6'd1;
        end else begin
          pts = {hdr_bytes[5], hdr_bytes[4]};
          tms = {hdr_bytes[7], hdr_bytes[6]};
          if (hdr_bytes[0] != regs.expected_version) err = ERR_VERSION;
          else if (pts == 16'd0 || pts > 16'(regs.max_points)) err = ERR_POINTS;
          else if (tms > 16'(regs.max_time_samples)) err = ERR_TIMES;
          else err = ERR_NONE;
          if (err != ERR_NONE) begin
            due_frame_results.push_back(frame_header_result(KIND_HDR_BAD, err, 1'b1));
            case (err)
              ERR_VERSION: bad_version_count_o++;
              ERR_POINTS:  bad_points_count_o++;
              default:     bad_times_count_o++;
            endcase
            rearm_hunt();
          end else begin
            due_frame_results.push_back(frame_header_result(KIND_HDR_OK, ERR_NONE, 1'b0));
            hdr_ok_count_o++;
            phase          = IN_POINTS;
            payload_offset = '0;
            hdr_offset     = '0;
          end
        end
      end
      default: begin
        in_points   = (phase == IN_POINTS);
        total       = in_points ? hdr_bytes[4] : hdr_bytes[6];
        section_end = (9'(payload_offset) + 9'd1 >= 9'(total));
        frame_end   = section_end && (!in_points || hdr_bytes[6] == 8'd0);
        r = frame_header_result(in_points ? KIND_POINT : KIND_TIME, ERR_NONE, frame_end);
        r.sample_value = b;
        r.sample_index = payload_offset;
        due_frame_results.push_back(r);
        payload_count_o++;
        if (frame_end) begin
          rearm_hunt();
        end else if (section_end) begin
          phase          = IN_TIMES;
          payload_offset = '0;
        end else begin
          payload_offset = payload_offset + 8'd1;
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs = '{sync_word: 32'h0, expected_version: 8'd1, max_points: 8'd255,
               max_time_samples: 8'd255};
      rearm_hunt();
      due_frame_results.delete();
      due_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_SYNC_WORD:   regs.sync_word        = cfg_wdata_i;
          REG_EXP_VERSION: regs.expected_version = cfg_wdata_i[7:0];
          REG_MAX_POINTS:  regs.max_points       = cfg_wdata_i[7:0];
          default:         regs.max_time_samples = cfg_wdata_i[7:0];
        endcase
      end
      if (s_tvalid_i && s_tready_i) advance_deframer(s_tdata_i);
      if (m_tvalid_i && m_tready_i) begin
        if (due_frame_results.size() == 0) begin
          $error("Unexpected result accepted: kind %0d, tdata 0x%0h", m_tuser_i, m_tdata_i);
          fail_count_o++;
        end else begin
          want = due_frame_results.pop_front();
          check_field("result_kind", want.result_kind, m_tuser_i);
          check_field("error_code", want.error_code, m_tdata_i[1:0]);
          check_field("sequence_res", want.sequence_res, m_tdata_i[17:2]);
          check_field("frame_flags", want.frame_flags, m_tdata_i[25:18]);
          check_field("point_total", want.point_total, m_tdata_i[33:26]);
          check_field("time_total", want.time_total, m_tdata_i[41:34]);
          check_field("peak_bits", want.peak_bits, m_tdata_i[73:42]);
          check_field("rms_bits", want.rms_bits, m_tdata_i[105:74]);
          check_field("sample_value", want.sample_value, m_tdata_i[113:106]);
          check_field("sample_index", want.sample_index, m_tdata_i[121:114]);
          check_field("frame_last", want.frame_last, m_tlast_i);
        end
      end
      due_count_o <= due_frame_results.size();
    end
  end

endmodule

// ----- tb/sync_word_frame_deframer_top_tb.sv -----
module sync_word_frame_deframer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import swfd_pkg::*;

  localparam int unsigned HDR_LEN       = HEADER_BYTES_DEF;
  localparam int unsigned STREAM_BYTES  = 1550;
  localparam int unsigned SETTING_COUNT = 6;
  localparam int unsigned IDLE_LIMIT    = 5000;

  logic                  clk_i;
  logic                  rst_ni;
  logic [7:0]            s_axis_tdata;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic                  cfg_we_i;
  logic [1:0]            cfg_addr_i;
  logic [31:0]           cfg_wdata_i;

  int unsigned fail_count;
  int unsigned due_count;
  int unsigned hdr_ok_count;
  int unsigned bad_version_count;
  int unsigned bad_points_count;
  int unsigned bad_times_count;
  int unsigned payload_count;

  cfg_t        cfg_cur;
  int unsigned bytes_sent;
  int unsigned burst_left;
  int unsigned idle_cycles;
  int unsigned ready_left;
  logic [31:0] ready_pattern;

  sync_word_frame_deframer_top #(
    .HEADER_BYTES(HDR_LEN)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tdata,
    .s_axis_tvalid,
    .s_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i
  );

  swfd_frame_checker #(
    .HEADER_BYTES(HDR_LEN)
  ) i_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .s_tdata_i           (s_axis_tdata),
    .s_tvalid_i          (s_axis_tvalid),
    .s_tready_i          (s_axis_tready),
    .m_tdata_i           (m_axis_tdata),
    .m_tuser_i           (m_axis_tuser),
    .m_tlast_i           (m_axis_tlast),
    .m_tvalid_i          (m_axis_tvalid),
    .m_tready_i          (m_axis_tready),
    .cfg_we_i            (cfg_we_i),
    .cfg_addr_i          (cfg_addr_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .fail_count_o        (fail_count),
    .due_count_o         (due_count),
    .hdr_ok_count_o      (hdr_ok_count),
    .bad_version_count_o (bad_version_count),
    .bad_points_count_o  (bad_points_count),
    .bad_times_count_o   (bad_times_count),
    .payload_count_o     (payload_count)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    logic [31:0] fresh;
    if (ready_left == 0) begin
      case ($urandom_range(0, 2))
        0:       fresh = '1;
        default: fresh = $urandom;
      endcase
      ready_left    <= 31;
      ready_pattern <= {fresh[0], fresh[31:1]};
      m_axis_tready <= fresh[0];
    end else begin
      ready_left    <= ready_left - 1;
      ready_pattern <= {ready_pattern[0], ready_pattern[31:1]};
      m_axis_tready <= ready_pattern[0];
    end
  end

  // Ends the run when idle_cycles, cleared by any accepted request, reaches IDLE_LIMIT.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $error("No request accepted for %0d cycles, %0d results outstanding",
             IDLE_LIMIT, due_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) send_byte(w[8*i +: 8]);
  endtask

  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_count(input int unsigned lo, input int unsigned hi);
    if (hi < lo) return lo;
    if ($urandom_range(0, 79) == 0) return hi;
    return lo + $urandom_range(0, (hi - lo < 5) ? hi - lo : 5);
  endfunction

  function automatic logic [15:0] count_above(input logic [7:0] limit);
    if (limit == 8'hFF || $urandom_range(0, 2) == 0) begin
      return {8'($urandom_range(1, 255)), 8'($urandom)};
    end
    return 16'($urandom_range(int'(limit) + 1, 255));
  endfunction

  task automatic send_frame_fields(input logic [7:0] ver, input logic [15:0] pts,
                                   input logic [15:0] tms);
    logic [15:0] seq;
    seq = 16'($urandom);
    send_word(cfg_cur.sync_word);
    send_byte(ver);
    send_byte(8'($urandom));
    send_byte(seq[7:0]);
    send_byte(seq[15:8]);
    send_byte(pts[7:0]);
    send_byte(pts[15:8]);
    send_byte(tms[7:0]);
    send_byte(tms[15:8]);
    send_word($urandom);
    send_word($urandom);
    repeat (HDR_LEN - 20) send_byte(8'($urandom));
    if (ver == cfg_cur.expected_version && pts != 16'd0 && pts <= 16'(cfg_cur.max_points) &&
        tms <= 16'(cfg_cur.max_time_samples)) begin
      repeat (int'(pts) + int'(tms)) send_byte(payload_byte());
    end
  endtask

  task automatic send_frame(input logic [1:0] flaw);
    logic [7:0]  ver;
    logic [15:0] pts;
    logic [15:0] tms;
    ver = cfg_cur.expected_version;
    pts = 16'(pick_count(1, cfg_cur.max_points));
    tms = 16'(pick_count(0, cfg_cur.max_time_samples));
    case (flaw)
      ERR_VERSION: ver = ver ^ 8'($urandom_range(1, 255));
      ERR_POINTS:  pts = ($urandom_range(0, 2) == 0) ? 16'd0 : count_above(cfg_cur.max_points);
      ERR_TIMES:   tms = count_above(cfg_cur.max_time_samples);
      default: ;
    endcase
    send_frame_fields(ver, pts, tms);
  endtask

  task automatic random_frame();
    int unsigned pick;
    int unsigned k;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
    end else if (pick < 14) begin
      k = $urandom_range(1, 3);
      for (int i = 0; i < k; i++) send_byte(cfg_cur.sync_word[8*i +: 8]);
      send_byte(cfg_cur.sync_word[8*k +: 8] ^ 8'($urandom_range(1, 255)));
    end else if (pick < 32) begin
      case ($urandom_range(0, 2))
        0:       send_frame(ERR_VERSION);
        1:       send_frame(ERR_POINTS);
        default: send_frame(ERR_TIMES);
      endcase
    end else begin
      send_frame(ERR_NONE);
    end
  endtask

  task automatic drain_results(input int unsigned tail);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (due_count != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic apply_config(input cfg_t c);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_SYNC_WORD;
    cfg_wdata_i <= c.sync_word;
    @(posedge clk_i);
    cfg_addr_i  <= REG_EXP_VERSION;
    cfg_wdata_i <= {24'd0, c.expected_version};
    @(posedge clk_i);
    cfg_addr_i  <= REG_MAX_POINTS;
    cfg_wdata_i <= {24'd0, c.max_points};
    @(posedge clk_i);
    cfg_addr_i  <= REG_MAX_TIMES;
    cfg_wdata_i <= {24'd0, c.max_time_samples};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_cur = c;
  endtask

  initial begin
    cfg_t next_cfg;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tvalid = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = REG_SYNC_WORD;
    cfg_wdata_i   = '0;
    ready_pattern = '0;
    cfg_cur = '{sync_word: 32'h0, expected_version: 8'd1, max_points: 8'd255,
                max_time_samples: 8'd255};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < SETTING_COUNT; p++) begin
      if (p == 0) begin
        // The reset settings hunt for an all-zero sync word, so the lead-in is nonzero.
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'hFF);
        send_frame_fields(8'd1, 16'd1, 16'd0);
        send_frame_fields(8'd1, 16'd3, 16'd2);
        send_frame_fields(8'hFE, 16'd0, 16'h1234);
        send_frame_fields(8'd1, 16'd0, 16'd5);
        send_frame_fields(8'd1, 16'h0100, 16'd0);
        send_frame_fields(8'd1, 16'd2, 16'h0100);
        send_frame_fields(8'd1, 16'd255, 16'd255);
      end else begin
        drain_results(4);
        case (p)
          1: next_cfg = '{sync_word: 32'hFFFF_FFFF, expected_version: 8'h00,
                          max_points: 8'd1, max_time_samples: 8'd0};
          2: next_cfg = '{sync_word: $urandom, expected_version: 8'hFF,
                          max_points: 8'd255, max_time_samples: 8'd255};
          // A point limit of zero makes every header with the right version fail.
          3: next_cfg = '{sync_word: $urandom, expected_version: 8'($urandom),
                          max_points: 8'd0, max_time_samples: 8'($urandom)};
          4: next_cfg = '{sync_word: $urandom, expected_version: 8'($urandom),
                          max_points: 8'($urandom_range(1, 255)),
                          max_time_samples: 8'($urandom_range(0, 255))};
          default: next_cfg = '{sync_word: 32'h0, expected_version: 8'($urandom),
                                max_points: 8'($urandom_range(1, 8)),
                                max_time_samples: 8'($urandom_range(0, 8))};
        endcase
        apply_config(next_cfg);
      end
      while (bytes_sent < (p + 1) * STREAM_BYTES / SETTING_COUNT) random_frame();
    end

    drain_results(16);
    $display("Streamed %0d bytes under %0d register settings with random gaps and stalls.",
             bytes_sent, SETTING_COUNT);
    $display("Headers: %0d accepted, rejected for version %0d, point count %0d, %s %0d; %0d %s",
             hdr_ok_count, bad_version_count, bad_points_count, "time count",
             bad_times_count, payload_count, "payload bytes checked.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
